/* sv/gaussian_blur_3x3_rgb_assert.svh */
// assertion macros for the 3x3 gaussian blur block
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef GAUSSIAN_BLUR_3X3_RGB_ASSERT_SVH
`define GAUSSIAN_BLUR_3X3_RGB_ASSERT_SVH

`ifndef ASSERT_OFF

`define GB3_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gb3 assertion failed");

`define GB3_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gb3 assertion failed");

`else

`define GB3_ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define GB3_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* sv/gb3_pkg.sv */
// constants and register map of the 3x3 gaussian blur block
// no dependencies
package gb3_pkg;

   localparam int POS_BITS  = 12;
   localparam int DIM_BITS  = 13;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 4;

   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_FIRST_ROW    = 2'd2;
   localparam logic [1:0] REG_END_ROW      = 2'd3;

   localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [POS_BITS-1:0] FIRST_RESET  = 12'd1;
   localparam logic [POS_BITS-1:0] END_RESET    = 12'd479;

   localparam logic [DIM_BITS-1:0] MIN_DIM    = 13'd3;
   localparam logic [DIM_BITS-1:0] MAX_HEIGHT = 13'd4096;

   localparam int KERNEL_TAPS  = 9;
   localparam int KERNEL_SHIFT = 4;
   localparam int unsigned KERNEL_GAIN [KERNEL_TAPS] = '{1, 2, 1, 2, 4, 2, 1, 2, 1};

   typedef logic [1:0] reg_index_type;

endpackage

/* sv/gb3_req_if.sv */
// pixel input channel of the 3x3 gaussian blur block
// valid/ready handshake with frame start flag and rgb payload
interface gb3_req_if #(
   parameter int CHANNEL_BITS = 8
);
   logic                    valid;
   logic                    ready;
   logic                    frame_start;
   logic [CHANNEL_BITS-1:0] red_in;
   logic [CHANNEL_BITS-1:0] green_in;
   logic [CHANNEL_BITS-1:0] blue_in;

   modport source (output valid, frame_start, red_in, green_in, blue_in, input ready);
   modport sink (input valid, frame_start, red_in, green_in, blue_in, output ready);
endinterface

/* sv/gb3_rsp_if.sv */
// blurred pixel output channel of the 3x3 gaussian blur block
// valid/ready handshake with position and rgb payload
interface gb3_rsp_if #(
   parameter int CHANNEL_BITS = 8
);
   logic                    valid;
   logic                    ready;
   logic [11:0]             out_row;
   logic [11:0]             out_col;
   logic [CHANNEL_BITS-1:0] red_out;
   logic [CHANNEL_BITS-1:0] green_out;
   logic [CHANNEL_BITS-1:0] blue_out;

   modport source (output valid, out_row, out_col, red_out, green_out, blue_out, input ready);
   modport sink (input valid, out_row, out_col, red_out, green_out, blue_out, output ready);
endinterface

/* sv/gaussian_blur_3x3_rgb.sv */
// streaming 3x3 gaussian blur, top level; uses gb3_pkg, gb3_req_if, gb3_rsp_if, gb3_ram
// throughput: one pixel per cycle while the output is not stalled; the line store read is
// issued at accept and the window, kernel sum and bypass complete in the following stage
// reset: counters, window, pipeline valid flags and configuration registers to defaults;
// line stores are not cleared and need no clearing pass
`include "gaussian_blur_3x3_rgb_assert.svh"

module gaussian_blur_3x3_rgb
   import gb3_pkg::*;
#(
   parameter int MAX_WIDTH    = 4096,
   parameter int CHANNEL_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   gb3_req_if.sink                  req_bus,
   gb3_rsp_if.source                rsp_bus,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);
   localparam int CB = CHANNEL_BITS;
   localparam int PW = 3 * CB;
   localparam int SW = CB + KERNEL_SHIFT;
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WB = ($clog2(MAX_WIDTH + 1) > DIM_BITS) ? $clog2(MAX_WIDTH + 1) : DIM_BITS;

   // configuration registers
   logic [DIM_BITS-1:0] width_ff;
   logic [DIM_BITS-1:0] height_ff;
   logic [POS_BITS-1:0] first_ff;
   logic [POS_BITS-1:0] end_ff;
   logic                csr_wr;
   reg_index_type       csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         first_ff  <= FIRST_RESET;
         end_ff    <= END_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_IMAGE_WIDTH:  width_ff  <= csr_pwdata[DIM_BITS-1:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_pwdata[DIM_BITS-1:0];
            REG_FIRST_ROW:    first_ff  <= csr_pwdata[POS_BITS-1:0];
            REG_END_ROW:      end_ff    <= csr_pwdata[POS_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_IMAGE_WIDTH:  csr_prdata = CSR_DATA_BITS'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = CSR_DATA_BITS'(height_ff);
         REG_FIRST_ROW:    csr_prdata = CSR_DATA_BITS'(first_ff);
         REG_END_ROW:      csr_prdata = CSR_DATA_BITS'(end_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // effective geometry and band
   logic [WB-1:0]       eff_w;
   logic [DIM_BITS-1:0] eff_h;
   logic [POS_BITS-1:0] band_lo;
   logic [DIM_BITS-1:0] band_hi;
   logic [DIM_BITS-1:0] h_m1;

   always_comb begin
      if (width_ff < MIN_DIM) begin
         eff_w = WB'(MIN_DIM);
      end else if (WB'(width_ff) > WB'(MAX_WIDTH)) begin
         eff_w = WB'(MAX_WIDTH);
      end else begin
         eff_w = WB'(width_ff);
      end
      if (height_ff < MIN_DIM) begin
         eff_h = MIN_DIM;
      end else if (height_ff > MAX_HEIGHT) begin
         eff_h = MAX_HEIGHT;
      end else begin
         eff_h = height_ff;
      end
      h_m1    = eff_h - DIM_BITS'(1);
      band_lo = (first_ff == '0) ? POS_BITS'(1) : first_ff;
      band_hi = (DIM_BITS'(end_ff) < h_m1) ? DIM_BITS'(end_ff) : h_m1;
   end

   // position counters and accept stage
   logic [AW-1:0]       col_ff, col_in;
   logic [POS_BITS-1:0] row_ff, row_in;
   logic [AW-1:0]       col_pre, cur_col;
   logic [POS_BITS-1:0] row_pre, cur_row, row_m1;
   logic [WB-1:0]       col_p1;
   logic [AW-1:0]       col_m1;
   logic                cur_emit;
   logic                req_accept;
   logic                s1_go;

   always_comb begin
      col_pre = req_bus.frame_start ? '0 : col_ff;
      row_pre = req_bus.frame_start ? '0 : row_ff;
      if (WB'(col_pre) >= eff_w) begin
         cur_col = '0;
         cur_row = row_pre + POS_BITS'(1);
      end else begin
         cur_col = col_pre;
         cur_row = row_pre;
      end
      col_p1 = WB'(cur_col) + WB'(1);
      if (col_p1 >= eff_w) begin
         col_in = '0;
         row_in = cur_row + POS_BITS'(1);
      end else begin
         col_in = col_p1[AW-1:0];
         row_in = cur_row;
      end
      row_m1     = cur_row - POS_BITS'(1);
      col_m1     = cur_col - AW'(1);
      cur_emit   = (cur_row >= POS_BITS'(2)) && (cur_col >= AW'(2)) &&
                   (row_m1 >= band_lo) && (DIM_BITS'(row_m1) < band_hi);
   end

   assign req_accept    = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // window stage registers
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_emit_ff;
   logic [PW-1:0]       s1_px_ff;
   logic [AW-1:0]       s1_col_ff;
   logic [POS_BITS-1:0] s1_orow_ff;
   logic [POS_BITS-1:0] s1_ocol_ff;
   logic                byp_hit_ff, byp_hit_in;
   logic [PW-1:0]       byp_upper_ff;
   logic [PW-1:0]       byp_middle_ff;
   logic [PW-1:0]       ram_up_q, ram_mid_q;
   logic [PW-1:0]       up_rd, mid_rd;
   logic                rsp_valid_ff, rsp_valid_in;

   assign s1_go       = s1_valid_ff && (!s1_emit_ff || !rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_go;
   assign s1_valid_in = req_accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   // previous pixel writes the same column in this cycle
   assign byp_hit_in  = s1_go && (s1_col_ff == cur_col);
   assign up_rd       = byp_hit_ff ? byp_upper_ff : ram_up_q;
   assign mid_rd      = byp_hit_ff ? byp_middle_ff : ram_mid_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         byp_hit_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (req_accept) begin
            byp_hit_ff <= byp_hit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_emit_ff    <= cur_emit;
         s1_px_ff      <= {req_bus.blue_in, req_bus.green_in, req_bus.red_in};
         s1_col_ff     <= cur_col;
         s1_orow_ff    <= row_m1;
         s1_ocol_ff    <= POS_BITS'(col_m1);
         byp_upper_ff  <= mid_rd;
         byp_middle_ff <= s1_px_ff;
      end
   end

   gb3_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_upper_ram (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_col_ff),
      .wr_data (mid_rd),
      .rd_en   (req_accept),
      .rd_addr (cur_col),
      .rd_data (ram_up_q)
   );

   gb3_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_middle_ram (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_col_ff),
      .wr_data (s1_px_ff),
      .rd_en   (req_accept),
      .rd_addr (cur_col),
      .rd_data (ram_mid_q)
   );

   // window columns c-1 and c-2, index 0 is top
   logic [PW-1:0] win1_ff [3];
   logic [PW-1:0] win2_ff [3];
   logic [PW-1:0] tap [KERNEL_TAPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            win1_ff[i] <= '0;
            win2_ff[i] <= '0;
         end
      end else if (s1_go) begin
         for (int i = 0; i < 3; i++) begin
            win2_ff[i] <= win1_ff[i];
         end
         win1_ff[0] <= up_rd;
         win1_ff[1] <= mid_rd;
         win1_ff[2] <= s1_px_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tap[i]     = win2_ff[i];
         tap[3 + i] = win1_ff[i];
      end
      tap[6] = up_rd;
      tap[7] = mid_rd;
      tap[8] = s1_px_ff;
   end

   logic [CB-1:0] blur [3];

   for (genvar k = 0; k < 3; k++) begin : gen_chan
      logic [SW-1:0] sum;
      always_comb begin
         sum = '0;
         for (int i = 0; i < KERNEL_TAPS; i++) begin
            sum = sum + SW'(tap[i][k*CB +: CB]) * SW'(KERNEL_GAIN[i]);
         end
      end
      assign blur[k] = sum[KERNEL_SHIFT +: CB];
   end

   // result register
   logic [POS_BITS-1:0] rsp_row_ff, rsp_col_ff;
   logic [CB-1:0]       rsp_red_ff, rsp_green_ff, rsp_blue_ff;

   assign rsp_valid_in = (s1_go && s1_emit_ff) ? 1'b1 :
                         (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_emit_ff) begin
         rsp_row_ff   <= s1_orow_ff;
         rsp_col_ff   <= s1_ocol_ff;
         rsp_red_ff   <= blur[0];
         rsp_green_ff <= blur[1];
         rsp_blue_ff  <= blur[2];
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_row   = rsp_row_ff;
   assign rsp_bus.out_col   = rsp_col_ff;
   assign rsp_bus.red_out   = rsp_red_ff;
   assign rsp_bus.green_out = rsp_green_ff;
   assign rsp_bus.blue_out  = rsp_blue_ff;

   `GB3_ASSERT_NEXT(a_accept_fills_s1, clock, reset, req_accept, s1_valid_ff)
   `GB3_ASSERT_NEXT(a_col_in_range, clock, reset, req_accept, (WB'(col_ff) < eff_w))
   `GB3_ASSERT_IMPLIES(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff), $past(s1_emit_ff && s1_go))
endmodule

/* sv/gb3_ram.sv */
// generic simple dual port ram, one write and one registered read port
// no dependencies
module gb3_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* tb/testbench.sv */
// self-checking testbench for the streaming 3x3 gaussian blur block
// uses gb3_pkg, gb3_req_if, gb3_rsp_if and the gaussian_blur_3x3_rgb top level
// pixels and register writes are driven from here, blurred pixels are checked in order
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import gb3_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 2_000_000;
   localparam int unsigned LONG_HOLD     = 300;
   localparam int unsigned SETTLE_CYCLES = 6;
   localparam int unsigned RANDOM_PIXELS = 1500;
   localparam int unsigned CALM_FROM     = 1300;
   localparam int unsigned FRAME_CAP     = 200;
   localparam int unsigned LINE_DEPTH    = 4096;
   localparam int          NUM_PRESETS   = 8;
   localparam int          HOLD_PHASE    = 4;

   typedef struct packed {
      logic       frame_start;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_pixel_type;

   typedef struct packed {
      logic [11:0] row;
      logic [11:0] col;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } blurred_type;

   typedef struct packed {
      logic        frame_start;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        typed;
      logic [11:0] want_row;
      logic [11:0] want_col;
      logic [7:0]  want_red;
      logic [7:0]  want_green;
      logic [7:0]  want_blue;
   } opening_row_type;

   typedef struct packed {
      logic [12:0] img_w;
      logic [12:0] img_h;
      logic [11:0] band_first;
      logic [11:0] band_end;
   } csr_setting_type;

   // image 3 wide and 4 high: three magenta rows over a green row, then a frame restarted mid-row
   localparam opening_row_type OPENING_PIXELS [24] = '{
      '{1'b1, 8'd255, 8'd0, 8'd255, 1'b0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0},
      '{1'b0, 8'd255, 8'd0, 8'd255, 1'b0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0},
      '{1'b0, 8'd255, 8'd0, 8'd255, 1'b0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0},
      '{1'b0, 8'd255, 8'd0, 8'd255, 1'b0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0},
      '{1'b0, 8'd255, 8'd0, 8'd255, 1'b0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0},
      '{1'b0, 8'd255, 8'd0, 8'd255, 1'b0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0},
      '{1'b0, 8'd255, 8'd0, 8'd255, 1'b0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0},
      '{1'b0, 8'd255, 8'd0, 8'd255, 1'b0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0},
      '{1'b0, 8'd255, 8'd0, 8'd255, 1'b1, 12'd1, 12'd1, 8'd255, 8'd0, 8'd255},
      '{1'b0, 8'd0, 8'd255, 8'd0, 1'b0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0},
      '{1'b0, 8'd0, 8'd255, 8'd0, 1'b0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0},
      '{1'b0, 8'd0, 8'd255, 8'd0, 1'b1, 12'd2, 12'd1, 8'd191, 8'd63, 8'd191},
      '{1'b1, 8'h01, 8'h02, 8'h04, 1'b0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0},
      '{1'b0, 8'h08, 8'h10, 8'h20, 1'b0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0},
      '{1'b1, 8'h40, 8'h80, 8'hFE, 1'b0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0},
      '{1'b0, 8'hFD, 8'hFB, 8'hF7, 1'b0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0},
      '{1'b0, 8'hEF, 8'hDF, 8'hBF, 1'b0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0},
      '{1'b0, 8'h7F, 8'h5A, 8'hA5, 1'b0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0},
      '{1'b0, 8'h3C, 8'hC3, 8'h99, 1'b0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0},
      '{1'b0, 8'h66, 8'h00, 8'hFF, 1'b0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0},
      '{1'b0, 8'h11, 8'h22, 8'h33, 1'b0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0},
      '{1'b0, 8'h44, 8'h55, 8'h66, 1'b0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0},
      '{1'b0, 8'h77, 8'h88, 8'h99, 1'b0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0},
      '{1'b0, 8'hAA, 8'hBB, 8'hCC, 1'b0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0}
   };

   localparam csr_setting_type PRESETS [NUM_PRESETS] = '{
      '{13'd0,    13'd5,    12'd0,    12'd4095},
      '{13'd2,    13'd0,    12'd1,    12'd2},
      '{13'd1,    13'd8191, 12'd4094, 12'd4095},
      '{13'd9,    13'd7,    12'd5,    12'd3},
      '{13'd12,   13'd10,   12'd1,    12'd4095},
      '{13'd3,    13'd5,    12'd1,    12'd4095},
      '{13'd4096, 13'd4096, 12'd0,    12'd4095},
      '{13'd8191, 13'd3,    12'd4095, 12'd0}
   };

   logic clock;
   logic reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   gb3_req_if #(.CHANNEL_BITS(8)) req_bus ();
   gb3_rsp_if #(.CHANNEL_BITS(8)) rsp_bus ();

   gaussian_blur_3x3_rgb dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // blur predictor state
   logic [23:0] upper_line  [LINE_DEPTH];
   logic [23:0] middle_line [LINE_DEPTH];
   bit          upper_written  [LINE_DEPTH];
   bit          middle_written [LINE_DEPTH];
   logic [23:0] win_left1 [3] = '{24'd0, 24'd0, 24'd0};
   logic [23:0] win_left2 [3] = '{24'd0, 24'd0, 24'd0};
   int unsigned col_pos = 0;
   logic [11:0] row_pos = '0;
   logic [12:0] cfg_width  = 13'd640;
   logic [12:0] cfg_height = 13'd480;
   logic [11:0] cfg_first  = 12'd1;
   logic [11:0] cfg_end    = 12'd479;

   blurred_type blurred_due [$];
   int unsigned errors = 0;
   int unsigned blurred_checked = 0;
   int unsigned pixels_sent = 0;
   int unsigned settings_used = 0;
   int unsigned cycles = 0;
   bit          calm = 0;
   bit          tx_idle_on = 1;
   bit          rx_idle_on = 1;
   bit          rx_long_hold = 0;
   int unsigned rx_hold_left = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic flag_error(input string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
   endtask

   function automatic int unsigned clamp_dim(input logic [12:0] v);
      if (v < 13'd3) return 3;
      if (v > 13'd4096) return 4096;
      return v;
   endfunction

   function automatic bit stores_cover(input int unsigned w);
      for (int unsigned c = 0; c < w; c++) begin
         if (!upper_written[c] || !middle_written[c]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic bit blur_pixel(input rgb_pixel_type px, output blurred_type res);
      int unsigned w, h, r, c, lo, hi, sum, gain;
      logic [23:0] tap [9];
      logic [7:0]  chan_out [3];
      bit          hit;
      w = clamp_dim(cfg_width);
      h = clamp_dim(cfg_height);
      if (px.frame_start) begin
         col_pos = 0;
         row_pos = '0;
      end
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = row_pos + 12'd1;
      end
      r = row_pos;
      c = col_pos;
      for (int y = 0; y < 3; y++) begin
         tap[y]     = win_left2[y];
         tap[3 + y] = win_left1[y];
      end
      tap[6] = upper_line[c];
      tap[7] = middle_line[c];
      tap[8] = {px.blue, px.green, px.red};
      lo = (cfg_first < 12'd1) ? 1 : cfg_first;
      hi = (cfg_end < h - 1) ? cfg_end : h - 1;
      hit = (r >= 2) && (c >= 2) && (r - 1 >= lo) && (r - 1 < hi);
      res = '0;
      if (hit) begin
         for (int k = 0; k < 3; k++) begin
            sum = 0;
            for (int x = 0; x < 3; x++) begin
               for (int y = 0; y < 3; y++) begin
                  gain = ((x == 1) ? 2 : 1) * ((y == 1) ? 2 : 1);
                  sum += tap[x * 3 + y][8 * k +: 8] * gain;
               end
            end
            chan_out[k] = 8'(sum >> 4);
         end
         res.row   = 12'(r - 1);
         res.col   = 12'(c - 1);
         res.red   = chan_out[0];
         res.green = chan_out[1];
         res.blue  = chan_out[2];
      end
      for (int y = 0; y < 3; y++) begin
         win_left2[y] = tap[3 + y];
         win_left1[y] = tap[6 + y];
      end
      upper_line[c]     = tap[7];
      middle_line[c]    = tap[8];
      upper_written[c]  = middle_written[c];
      middle_written[c] = 1'b1;
      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = row_pos + 12'd1;
      end
      return hit;
   endfunction

   function automatic logic [7:0] channel_value();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic sender_gap(input int unsigned n);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic send_pixel(input rgb_pixel_type px, input bit typed, input blurred_type want);
      blurred_type predicted;
      bit          hit;
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.frame_start <= px.frame_start;
      req_bus.red_in      <= px.red;
      req_bus.green_in    <= px.green;
      req_bus.blue_in     <= px.blue;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      hit = blur_pixel(px, predicted);
      if (typed) blurred_due.push_back(want);
      else if (hit) blurred_due.push_back(predicted);
      pixels_sent++;
      if ($urandom_range(0, 299) == 0) tx_idle_on = !tx_idle_on;
      if (!calm && tx_idle_on && $urandom_range(0, 5) == 0) sender_gap($urandom_range(1, 10));
   endtask

   task automatic feed_frame(input int unsigned count, input bit start, input bit noisy);
      rgb_pixel_type px;
      blurred_type   none;
      none = '0;
      for (int unsigned i = 0; i < count; i++) begin
         px.frame_start = (i == 0) ? start : (noisy && $urandom_range(0, 39) == 0);
         px.red   = channel_value();
         px.green = channel_value();
         px.blue  = channel_value();
         send_pixel(px, 1'b0, none);
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (blurred_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input reg_index_type idx, input bit wr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      logic [31:0] unused;
      csr_access(idx, 1'b1, value, unused);
      case (idx)
         REG_IMAGE_WIDTH:  cfg_width  = value[12:0];
         REG_IMAGE_HEIGHT: cfg_height = value[12:0];
         REG_FIRST_ROW:    cfg_first  = value[11:0];
         REG_END_ROW:      cfg_end    = value[11:0];
         default: ;
      endcase
   endtask

   task automatic check_registers();
      logic [31:0] got, want;
      for (int i = 0; i < 4; i++) begin
         case (reg_index_type'(i))
            REG_IMAGE_WIDTH:  want = {19'd0, cfg_width};
            REG_IMAGE_HEIGHT: want = {19'd0, cfg_height};
            REG_FIRST_ROW:    want = {20'd0, cfg_first};
            default:          want = {20'd0, cfg_end};
         endcase
         csr_access(reg_index_type'(i), 1'b0, 32'd0, got);
         if (got !== want)
            flag_error($sformatf("register %0d readback: expected %0d, got %0d", i, want, got));
      end
   endtask

   task automatic apply_setting(input csr_setting_type s);
      logic [31:0] junk;
      junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
      csr_write(REG_IMAGE_WIDTH,  {junk[31:13], s.img_w});
      csr_write(REG_IMAGE_HEIGHT, {junk[31:13], s.img_h});
      csr_write(REG_FIRST_ROW,    {junk[31:12], s.band_first});
      csr_write(REG_END_ROW,      {junk[31:12], s.band_end});
      settings_used++;
      check_registers();
   endtask

   always @(negedge clock) begin
      if (rx_long_hold) begin
         rx_hold_left = LONG_HOLD;
         rx_long_hold = 1'b0;
      end
      if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!calm && rx_idle_on && $urandom_range(0, 7) == 0) begin
         rx_hold_left = $urandom_range(0, 9);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
      if ($urandom_range(0, 299) == 0) rx_idle_on = !rx_idle_on;
   end

   always @(posedge clock) begin
      blurred_type got, want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got = {rsp_bus.out_row, rsp_bus.out_col, rsp_bus.red_out, rsp_bus.green_out,
                rsp_bus.blue_out};
         if (blurred_due.size() == 0) begin
            flag_error($sformatf("unexpected blurred pixel: row %0d col %0d rgb %0d %0d %0d",
                                 got.row, got.col, got.red, got.green, got.blue));
         end else begin
            want = blurred_due.pop_front();
            blurred_checked++;
            if (got.row !== want.row || got.col !== want.col || got.red !== want.red ||
                got.green !== want.green || got.blue !== want.blue)
               flag_error($sformatf({"blurred pixel mismatch: expected row %0d col %0d ",
                                     "rgb %0d %0d %0d, got row %0d col %0d rgb %0d %0d %0d"},
                                    want.row, want.col, want.red, want.green, want.blue,
                                    got.row, got.col, got.red, got.green, got.blue));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d transactions outstanding", cycles,
                  blurred_due.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      csr_setting_type s;
      rgb_pixel_type   px;
      blurred_type     want;
      int unsigned     w, h, rows, count, frames, start_pixels, random_pixels;
      bit              start;

      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.frame_start = 1'b0;
      req_bus.red_in      = 8'd0;
      req_bus.green_in    = 8'd0;
      req_bus.blue_in     = 8'd0;
      rsp_bus.ready       = 1'b0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      random_pixels       = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values first
      check_registers();
      csr_write(REG_IMAGE_WIDTH, 32'd3);
      csr_write(REG_IMAGE_HEIGHT, 32'd4);
      foreach (OPENING_PIXELS[i]) begin
         px   = {OPENING_PIXELS[i].frame_start, OPENING_PIXELS[i].red,
                 OPENING_PIXELS[i].green, OPENING_PIXELS[i].blue};
         want = {OPENING_PIXELS[i].want_row, OPENING_PIXELS[i].want_col,
                 OPENING_PIXELS[i].want_red, OPENING_PIXELS[i].want_green,
                 OPENING_PIXELS[i].want_blue};
         send_pixel(px, OPENING_PIXELS[i].typed, want);
      end
      drain_results();

      for (int phase = 0; phase < NUM_PRESETS || random_pixels < RANDOM_PIXELS || !calm;
           phase++) begin
         if (phase < NUM_PRESETS) begin
            s = PRESETS[phase];
         end else begin
            s.img_w = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 2))
                                                  : 13'($urandom_range(3, 12));
            case ($urandom_range(0, 9))
               0: s.img_h = 13'($urandom_range(0, 2));
               1: s.img_h = 13'($urandom_range(13, 8191));
               default: s.img_h = 13'($urandom_range(3, 12));
            endcase
            case ($urandom_range(0, 9))
               0: s.band_first = 12'd0;
               1: s.band_first = 12'($urandom_range(0, 4095));
               default: s.band_first = 12'($urandom_range(0, 6));
            endcase
            case ($urandom_range(0, 9))
               0: s.band_end = 12'd4095;
               1: s.band_end = 12'($urandom_range(0, 4095));
               default: s.band_end = 12'($urandom_range(1, 12));
            endcase
         end
         apply_setting(s);
         w = clamp_dim(cfg_width);
         h = clamp_dim(cfg_height);
         case (phase)
            HOLD_PHASE: begin
               feed_frame(30, 1'b1, 1'b0);
               rx_long_hold = 1'b1;
               feed_frame(50, 1'b0, 1'b0);
               drain_results();
               feed_frame(40, 1'b0, 1'b0);
            end
            default: begin
               start_pixels = pixels_sent;
               if (random_pixels >= CALM_FROM) calm = 1'b1;
               frames = $urandom_range(1, 3);
               for (int f = 0; f < frames; f++) begin
                  rows = (h <= 10) ? h : $urandom_range(3, 10);
                  if ($urandom_range(0, 5) == 0) rows += $urandom_range(1, 3);
                  count = rows * w;
                  if (count > FRAME_CAP || $urandom_range(0, 7) == 0)
                     count = $urandom_range(1, (count > FRAME_CAP) ? FRAME_CAP : count);
                  start = (f != 0) || !stores_cover(w) || $urandom_range(0, 2) != 0;
                  feed_frame(count, start, 1'b1);
               end
               random_pixels += pixels_sent - start_pixels;
            end
         endcase
         drain_results();
      end

      $display("sent %0d pixels over %0d register settings, checked %0d blurred pixels",
               pixels_sent, settings_used, blurred_checked);
      $display("covered clamped sizes, empty and edge bands, frame restarts, long output stalls");
      if (blurred_due.size() != 0)
         flag_error($sformatf("%0d blurred pixels never arrived", blurred_due.size()));
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", errors);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
